>>> rtl/lzcd_pkg.sv
// shared types and constants for the lz control-bit decompressor
package lzcd_pkg;

	localparam int WIN_BYTES = 8192;
	localparam int HADDR_W = $clog2(WIN_BYTES);
	localparam int CNT_W = 25;
	localparam int LEN_W = 9;
	localparam int DIST_W = 14;
	localparam int LANES = 4;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam logic [CNT_W-1:0] CAP_LIMIT = 25'h1000000;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_LIT  = 2'd1,
		CMD_COPY = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         data;
		logic [LEN_W-1:0]   len;
		logic [DIST_W-1:0]  offs;
		logic               ended;
		logic               trunc;
	} cmd_t;

	typedef struct packed {
		logic [31:0]        data_word;
		logic [2:0]         byte_count;
		logic               run_last;
		logic               stream_end;
		logic [CNT_W-1:0]   total_length;
		logic               overflow;
		logic               truncated;
	} res_t;

endpackage

>>> rtl/lzcd_front.sv
// front end: control-bit decoding of source bytes into commands
module lzcd_front import lzcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	typedef enum logic [7:0] {
		PH_CTRL = 8'b0000_0001,
		PH_SEL  = 8'b0000_0010,
		PH_SA   = 8'b0000_0100,
		PH_SB   = 8'b0000_1000,
		PH_SOFF = 8'b0001_0000,
		PH_LCNT = 8'b0010_0000,
		PH_LPOS = 8'b0100_0000,
		PH_LEXT = 8'b1000_0000
	} phase_t;

	phase_t            phase_q, ph;
	logic [7:0]        cb_q, cb;
	logic [3:0]        bl_q, bl;
	logic              sa_q, sa;
	logic [7:0]        pl_q, pl;
	logic [DIST_W-1:0] off_q, off;
	logic              fin_q, fin;
	logic              accept;
	logic [DIST_W-1:0] ldist;
	logic              bitsel;

	assign in_ready  = cmd_ready;
	assign accept    = in_valid && cmd_ready;
	assign cmd_valid = accept && !fin_q;
	assign ldist     = DIST_W'(14'h2000 - ({1'b0, in_byte, 5'b0} + DIST_W'(pl_q[7:3])));

	always_comb begin
		ph  = phase_q;
		cb  = cb_q;
		bl  = bl_q;
		sa  = sa_q;
		pl  = pl_q;
		off = off_q;
		fin = fin_q;
		bitsel = 1'b0;
		cmd = '0;
		cmd.kind = CMD_NONE;
		if ((ph == PH_CTRL || ph == PH_SEL || ph == PH_SA || ph == PH_SB) && bl == 4'd0) begin
			cb = in_byte;
			bl = 4'd8;
		end else begin
			unique case (ph)
				PH_CTRL: begin
					cb = cb >> 1;
					bl = bl - 4'd1;
					cmd.kind = CMD_LIT;
					cmd.data = in_byte;
					cmd.len  = LEN_W'(1);
				end
				PH_SOFF: begin
					cmd.kind = CMD_COPY;
					cmd.len  = LEN_W'(pl);
					cmd.offs = DIST_W'(9'h100 - {1'b0, in_byte});
					ph = PH_CTRL;
				end
				PH_LCNT: begin
					pl = in_byte;
					ph = PH_LPOS;
				end
				PH_LPOS: begin
					if (pl_q == 8'd0 && in_byte == 8'd0) begin
						fin = 1'b1;
						cmd.ended = 1'b1;
					end else if (pl_q[2:0] != 3'd0) begin
						cmd.kind = CMD_COPY;
						cmd.len  = LEN_W'(pl_q[2:0]) + LEN_W'(2);
						cmd.offs = ldist;
						ph = PH_CTRL;
					end else begin
						off = ldist;
						ph = PH_LEXT;
					end
				end
				PH_LEXT: begin
					cmd.kind = CMD_COPY;
					cmd.len  = {1'b0, in_byte} + LEN_W'(1);
					cmd.offs = off_q;
					ph = PH_CTRL;
				end
				default: begin
					ph = phase_q;
				end
			endcase
		end
		if (!fin) begin
			for (int i = 0; i < 4; i++) begin
				if (bl != 4'd0 && !(ph == PH_CTRL && cb[0])) begin
					bitsel = cb[0];
					if (ph == PH_CTRL) begin
						ph = PH_SEL;
						cb = cb >> 1;
						bl = bl - 4'd1;
					end else if (ph == PH_SEL) begin
						ph = bitsel ? PH_LCNT : PH_SA;
						cb = cb >> 1;
						bl = bl - 4'd1;
					end else if (ph == PH_SA) begin
						sa = bitsel;
						ph = PH_SB;
						cb = cb >> 1;
						bl = bl - 4'd1;
					end else if (ph == PH_SB) begin
						pl = 8'd2 + {6'd0, sa, 1'b0} + {7'd0, bitsel};
						ph = PH_SOFF;
						cb = cb >> 1;
						bl = bl - 4'd1;
					end
				end
			end
		end
		if (in_last && !fin) begin
			cmd.trunc = 1'b1;
			fin = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CTRL;
			cb_q    <= '0;
			bl_q    <= '0;
			sa_q    <= 1'b0;
			pl_q    <= '0;
			off_q   <= '0;
			fin_q   <= 1'b0;
		end else if (accept && !fin_q) begin
			phase_q <= ph;
			cb_q    <= cb;
			bl_q    <= bl;
			sa_q    <= sa;
			pl_q    <= pl;
			off_q   <= off;
			fin_q   <= fin;
		end
	end

endmodule

>>> rtl/lzcd_fifo.sv
// command queue between front and back end
module lzcd_fifo import lzcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_pop,
	output cmd_t rd_data
);

	cmd_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wp_q, rp_q;
	logic [QPTR_W:0]    cnt_q;
	logic               push, pop;

	assign wr_ready = cnt_q != (QPTR_W+1)'(QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/lzcd_back.sv
// back end: history window, copy engine and result packing
module lzcd_back import lzcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] capacity,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  cmd_t             cmd,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SETUP = 5'b00010,
		ST_READ  = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_PUSH  = 5'b10000
	} state_t;

	logic [7:0]         hist_q [WIN_BYTES];
	state_t             state_q;
	cmd_t               cmd_q;
	logic [LEN_W-1:0]   rem_q;
	logic [2:0]         cnt_q;
	logic [31:0]        acc_q, acc_new;
	logic               ovf_q, zero_q;
	logic [CNT_W-1:0]   oc_q, oc_inc;
	logic [7:0]         rd_q, byte_w;
	logic               out_valid_q;
	res_t               out_q;
	logic               out_free, word_done, last_w, go_next;
	logic [CNT_W-1:0]   eff_cap, avail, len_x;
	logic [LEN_W-1:0]   emit_n;
	logic               over;
	logic [HADDR_W-1:0] raddr;

	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign out_free  = !out_valid_q || res_ready;
	assign oc_inc    = oc_q + CNT_W'(1);
	assign eff_cap   = capacity[CNT_W-1] ? CAP_LIMIT : capacity;
	assign avail     = (oc_q < eff_cap) ? eff_cap - oc_q : '0;
	assign len_x     = CNT_W'(cmd_q.len);
	assign over      = len_x > avail;
	assign emit_n    = over ? avail[LEN_W-1:0] : cmd_q.len;
	assign byte_w    = (cmd_q.kind == CMD_LIT) ? cmd_q.data : (zero_q ? 8'd0 : rd_q);
	assign word_done = cnt_q == 3'd3 || rem_q == LEN_W'(1);
	assign last_w    = rem_q == LEN_W'(1);
	assign raddr     = oc_q[HADDR_W-1:0] - cmd_q.offs[HADDR_W-1:0];
	assign go_next   = (state_q == ST_WRITE && word_done && out_free && last_w) ||
	                   (state_q == ST_PUSH && out_free && rem_q == '0) ||
	                   state_q == ST_IDLE;
	assign cmd_pop   = go_next && cmd_valid;

	always_comb begin
		acc_new = acc_q;
		unique case (cnt_q[1:0])
			2'd0: acc_new[7:0]   = byte_w;
			2'd1: acc_new[15:8]  = byte_w;
			2'd2: acc_new[23:16] = byte_w;
			2'd3: acc_new[31:24] = byte_w;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			hist_q[oc_q[HADDR_W-1:0]] <= byte_w;
		end
		if (state_q == ST_READ) begin
			rd_q <= hist_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			acc_q       <= '0;
			ovf_q       <= 1'b0;
			zero_q      <= 1'b0;
			oc_q        <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_SETUP: begin
					ovf_q <= ovf_q | over;
					rem_q <= emit_n;
					acc_q <= '0;
					cnt_q <= '0;
					if (emit_n == '0) begin
						state_q <= ST_PUSH;
					end else if (cmd_q.kind == CMD_LIT) begin
						state_q <= ST_WRITE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					zero_q  <= oc_q < CNT_W'(cmd_q.offs);
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					oc_q  <= oc_inc;
					rem_q <= rem_q - LEN_W'(1);
					if (word_done && out_free) begin
						out_valid_q        <= 1'b1;
						out_q.data_word    <= acc_new;
						out_q.byte_count   <= cnt_q + 3'd1;
						out_q.run_last     <= last_w;
						out_q.stream_end   <= last_w && cmd_q.ended;
						out_q.total_length <= oc_inc;
						out_q.overflow     <= ovf_q;
						out_q.truncated    <= last_w && cmd_q.trunc;
						acc_q <= '0;
						cnt_q <= '0;
						state_q <= last_w ? ST_IDLE : ST_READ;
					end else begin
						acc_q <= acc_new;
						cnt_q <= cnt_q + 3'd1;
						state_q <= word_done ? ST_PUSH : ST_READ;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						out_valid_q        <= 1'b1;
						out_q.data_word    <= acc_q;
						out_q.byte_count   <= cnt_q;
						out_q.run_last     <= rem_q == '0;
						out_q.stream_end   <= rem_q == '0 && cmd_q.ended;
						out_q.total_length <= oc_q;
						out_q.overflow     <= ovf_q;
						out_q.truncated    <= rem_q == '0 && cmd_q.trunc;
						acc_q <= '0;
						cnt_q <= '0;
						state_q <= (rem_q == '0) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (go_next) begin
				if (cmd_valid) begin
					cmd_q   <= cmd;
					state_q <= ST_SETUP;
				end else begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

endmodule

>>> rtl/lz_control_bit_decompressor.sv
// top level: lz control-bit decompressor with stream ports and capacity register
// commands pass the queue, then setup and write steps, then the output register
// in the back end a literal byte passes setup and write steps, a control byte setup and push
// copies take a setup step, then a history read and a write step per output byte
// results leave through one output register; up to 4 commands queue between front and back
// reset clears all control state; history reads zero until written, by a fill compare
module lz_control_bit_decompressor import lzcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // src_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // data_word, byte_count, total_length, zero fill
	output logic        m_axis_tlast,
	output logic [2:0]  m_axis_tuser,  // stream_end, overflow, truncated
	input  logic        cfg_we,
	input  logic [24:0] cfg_wdata
);

	logic [CNT_W-1:0] cap_q;
	logic             f_valid, f_ready, q_valid, q_pop;
	cmd_t             f_cmd, q_cmd;
	res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_LIMIT;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	lzcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	lzcd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_cmd),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_data  (q_cmd)
	);

	lzcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (cap_q),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cmd       (q_cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {4'd0, res.total_length, res.byte_count, res.data_word};
	assign m_axis_tlast = res.run_last;
	assign m_axis_tuser = {res.truncated, res.overflow, res.stream_end};

endmodule
